### sv/integer_partition_counter_defines.svh
// Assertion macros used by the checker file of the partition counter.
// Depends on nothing; expects i_clk and i_rst_n in the including scope.
`ifndef INTEGER_PARTITION_COUNTER_DEFINES_SVH
`define INTEGER_PARTITION_COUNTER_DEFINES_SVH

// Same-cycle implication, checked outside reset
`define IPC_ASSERT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("ipc check failed");

// Next-cycle implication, checked outside reset
`define IPC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("ipc check failed");

`endif

### sv/ipc_pkg.sv
// Shared widths and types of the integer partition counter.
// No dependencies.
package ipc_pkg;

    localparam int IN_W  = 8;   // width of count_in
    localparam int RES_W = 63;  // width of partitions
    localparam int ACC_W = 64;  // width of one table entry

    typedef logic [IN_W-1:0]  t_count;
    typedef logic [RES_W-1:0] t_result;
    typedef logic [ACC_W-1:0] t_acc;

endpackage

### sv/ipc_if.sv
// Valid/ready channel interfaces for requests and results.
// Depends on ipc_pkg.
interface ipc_req_if
    import ipc_pkg::*;
();
    logic   valid;
    logic   ready;
    t_count count_in;

    modport source (output valid, output count_in, input ready);
    modport sink   (input valid, input count_in, output ready);
endinterface

interface ipc_res_if
    import ipc_pkg::*;
();
    logic    valid;
    logic    ready;
    t_result partitions;

    modport source (output valid, output partitions, input ready);
    modport sink   (input valid, input partitions, output ready);
endinterface

### sv/ipc_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module ipc_ram #(
    parameter int WIDTH  = 64,
    parameter int DEPTH  = 256,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write, then read with old data on a same-address collision
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### sv/integer_partition_counter.sv
// Integer partition counter: returns p(n) for a requested count n.
// Requests come in on i_req (count_in), results leave on o_res (partitions),
// both valid/ready channels; a transaction moves when valid and ready are high.
// One request is worked on at a time. The row of partial counts lives in two
// mirrored RAMs (one read port each) of MAX_N+1 entries of 64 bits.
// For 1 <= n <= MAX_N the row is seeded in CLEAR, then RUN does read-add-write
// (one entry per cycle) for each part size k and each j from k to n, then DRAIN
// takes the last sum and HOLD loads it into the output register. n = 0 returns
// 1 and n > MAX_N returns 0, both going straight to HOLD after accept.
// i_req.ready is high only while idle; it returns high in the cycle the result
// is loaded into the output register, so a new request can start while the
// previous result waits. If the receiver stalls and a second result finishes,
// the block holds it until the output register frees up.
// Reset (i_rst_n low, synchronous) returns to idle and empties the output.
// RAM contents are never cleared; each request rewrites every entry it reads.
module integer_partition_counter
    import ipc_pkg::*;
#(
    parameter int MAX_N = 255
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    ipc_req_if.sink    i_req,
    ipc_res_if.source  o_res
);

    localparam int DEPTH = MAX_N + 1;
    localparam int AW    = $clog2(DEPTH);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CLEAR = 3'd1;
    localparam logic [2:0] S_RUN   = 3'd2;
    localparam logic [2:0] S_DRAIN = 3'd3;
    localparam logic [2:0] S_HOLD  = 3'd4;

    logic [2:0]    r_state, n_state;
    logic [AW-1:0] r_n, n_n;
    logic [AW-1:0] r_j, n_j;
    logic [AW-1:0] r_k, n_k;
    t_result       r_res, n_res;
    logic          r_out_vld, n_out_vld;
    t_result       r_out_data, n_out_data;

    // read-add-write pipeline stage
    logic          r_s1_vld;
    logic [AW-1:0] r_s1_j;
    logic          r_fwd_a, r_fwd_b;
    t_acc          r_fwd_data;

    logic          in_acc;
    logic          out_load;
    logic          issue;
    logic [AW-1:0] rd_a, rd_b;
    t_acc          a_q, b_q, sum;
    logic          we;
    logic [AW-1:0] waddr;
    t_acc          wdata;

    assign in_acc      = i_req.valid && i_req.ready;
    assign i_req.ready = (r_state == S_IDLE);
    assign o_res.valid = r_out_vld;
    assign o_res.partitions = r_out_data;

    assign out_load = (r_state == S_HOLD) && (!r_out_vld || o_res.ready);
    assign issue    = (r_state == S_RUN);

    // read addresses: p[j] and p[j-k]
    assign rd_a = r_j;
    assign rd_b = r_j - r_k;

    // add with forwarding of the entry written in the issue cycle
    assign sum = (r_fwd_a ? r_fwd_data : a_q) + (r_fwd_b ? r_fwd_data : b_q);

    // write port: seeding during CLEAR, else the pipeline result
    always_comb begin
        if (r_state == S_CLEAR) begin
            we    = 1'b1;
            waddr = r_j;
            wdata = (r_j == '0) ? t_acc'(1) : '0;
        end else begin
            we    = r_s1_vld;
            waddr = r_s1_j;
            wdata = sum;
        end
    end

    ipc_ram #(.WIDTH(ACC_W), .DEPTH(DEPTH), .ADDR_W(AW)) u_ram_a (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (rd_a),
        .o_rdata (a_q)
    );

    ipc_ram #(.WIDTH(ACC_W), .DEPTH(DEPTH), .ADDR_W(AW)) u_ram_b (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (rd_b),
        .o_rdata (b_q)
    );

    // sequencer and output register next state
    always_comb begin
        n_state    = r_state;
        n_n        = r_n;
        n_j        = r_j;
        n_k        = r_k;
        n_res      = r_res;
        n_out_vld  = r_out_vld;
        n_out_data = r_out_data;

        if (o_res.ready) begin
            n_out_vld = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    if ({1'b0, i_req.count_in} > 9'(MAX_N)) begin
                        n_res   = '0;
                        n_state = S_HOLD;
                    end else if (i_req.count_in == '0) begin
                        n_res   = t_result'(1);
                        n_state = S_HOLD;
                    end else begin
                        n_n     = AW'(i_req.count_in);
                        n_j     = '0;
                        n_state = S_CLEAR;
                    end
                end
            end
            S_CLEAR: begin
                if (r_j == r_n) begin
                    n_k     = AW'(1);
                    n_j     = AW'(1);
                    n_state = S_RUN;
                end else begin
                    n_j = r_j + AW'(1);
                end
            end
            S_RUN: begin
                if (r_j == r_n) begin
                    if (r_k == r_n) begin
                        n_state = S_DRAIN;
                    end else begin
                        // next part size starts at j = k
                        n_k = r_k + AW'(1);
                        n_j = r_k + AW'(1);
                    end
                end else begin
                    n_j = r_j + AW'(1);
                end
            end
            S_DRAIN: begin
                n_res   = sum[RES_W-1:0];
                n_state = S_HOLD;
            end
            S_HOLD: begin
                if (out_load) begin
                    n_out_vld  = 1'b1;
                    n_out_data = r_res;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_out_vld <= 1'b0;
            r_s1_vld  <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_out_vld <= n_out_vld;
            r_s1_vld  <= issue;
        end
    end

    // payload and counters
    always_ff @(posedge i_clk) begin
        r_n        <= n_n;
        r_j        <= n_j;
        r_k        <= n_k;
        r_res      <= n_res;
        r_out_data <= n_out_data;
        r_s1_j     <= r_j;
        r_fwd_a    <= r_s1_vld && (rd_a == r_s1_j);
        r_fwd_b    <= r_s1_vld && (rd_b == r_s1_j);
        r_fwd_data <= sum;
    end

endmodule

### sv/ipc_checker.sv
// Port-level checks of the integer partition counter, bound to its top level.
// Depends on ipc_pkg and integer_partition_counter_defines.svh.
`include "integer_partition_counter_defines.svh"

module ipc_checker
    import ipc_pkg::*;
(
    input logic    i_clk,
    input logic    i_rst_n,
    input logic    i_in_valid,
    input logic    i_in_ready,
    input t_count  i_count_in,
    input logic    i_out_valid,
    input logic    i_out_ready,
    input t_result i_partitions
);

    logic in_acc;
    assign in_acc = i_in_valid && i_in_ready;

    // one request at a time: busy right after a transaction
    `IPC_ASSERT_NEXT(a_busy_after_accept, in_acc, !i_in_ready)

    // a zero count answers 1 when the output is free at accept
    `IPC_ASSERT_NEXT(a_zero_count, in_acc && (i_count_in == '0) && !i_out_valid, ##1 (i_out_valid && (i_partitions == t_result'(1))))

    // a fresh result always comes with the block back to idle
    `IPC_ASSERT(a_idle_on_result, $rose(i_out_valid), i_in_ready)

    // a stalled result holds
    `IPC_ASSERT_NEXT(a_out_hold, i_out_valid && !i_out_ready, i_out_valid && $stable(i_partitions))

endmodule

bind integer_partition_counter ipc_checker u_ipc_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_req.valid),
    .i_in_ready   (i_req.ready),
    .i_count_in   (i_req.count_in),
    .i_out_valid  (o_res.valid),
    .i_out_ready  (o_res.ready),
    .i_partitions (o_res.partitions)
);

### dv/integer_partition_counter_test.sv
// Self-checking testbench for integer_partition_counter: drives counts on the request channel,
// predicts p(n) with its own partial-count row and compares every result in order.
// Depends on ipc_pkg, ipc_req_if / ipc_res_if and the integer_partition_counter RTL.
module integer_partition_counter_test;
    import ipc_pkg::*;

    localparam int MAX_COUNT    = 255;  // largest count the block builds a row for
    localparam int MAX_REPORTS  = 10;   // mismatches printed in full
    localparam int SETTLE_TICKS = 50;   // quiet time after the last result
    localparam int ITEM_SLACK   = 800;  // per-item allowance for gaps and stalls

    typedef enum {RX_OPEN, RX_CHOPPY, RX_LONG_STALL} t_rx_mode;
    typedef enum {TX_STEADY, TX_BURSTY} t_tx_mode;

    typedef struct {
        t_count  count;
        t_result partitions;
    } t_partition_answer;

    logic i_clk = 1'b0;
    logic i_rst_n;

    ipc_req_if req_ch ();
    ipc_res_if res_ch ();

    integer_partition_counter #(
        .MAX_N (MAX_COUNT)
    ) DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_res   (res_ch)
    );

    // Predictor state and the answers still owed by the block
    t_acc              count_row [0:MAX_COUNT];
    t_partition_answer owed_answers [$];

    int       mismatch_count = 0;
    longint   cycle_count    = 0;
    longint   cycle_limit    = 4000;
    t_rx_mode rx_mode        = RX_OPEN;
    t_tx_mode tx_mode        = TX_STEADY;
    bit       req_up         = 1'b0;
    int       burst_left     = 0;
    logic     ready_level    = 1'b1;
    int       ready_run      = 0;

    // Free-running clock
    always #6 i_clk = ~i_clk;

    // Row of partial counts: seed p[0]=1, then fold in part sizes 1..n
    function automatic t_result partitions_of(input t_count n);
        int cnt;
        int part;
        int idx;
        cnt = int'(n);
        if (cnt > MAX_COUNT) begin
            return '0;
        end
        count_row[0] = t_acc'(1);
        for (idx = 1; idx <= cnt; idx++) begin
            count_row[idx] = '0;
        end
        for (part = 1; part <= cnt; part++) begin
            for (idx = part; idx <= cnt; idx++) begin
                count_row[idx] = count_row[idx] + count_row[idx - part];
            end
        end
        return count_row[cnt][RES_W-1:0];
    endfunction

    // Send one count and wait for the transaction; bursts end in a random gap
    task automatic send_count(input t_count n);
        int cnt;
        cnt = int'(n);
        req_ch.valid    <= 1'b1;
        req_ch.count_in <= n;
        req_up = 1'b1;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        owed_answers.push_back('{count: n, partitions: partitions_of(n)});
        cycle_limit += 4 * (cnt * (cnt + 1) / 2 + cnt + 4) + ITEM_SLACK;
        if (tx_mode == TX_BURSTY) begin
            if (burst_left > 0) begin
                burst_left--;
            end else begin
                req_ch.valid    <= 1'b0;
                req_ch.count_in <= t_count'($urandom);
                req_up = 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge i_clk);
                burst_left = $urandom_range(0, 3);
            end
        end
    endtask

    // Drop valid after the last transaction of a phase
    task automatic stop_sending();
        if (req_up) begin
            req_ch.valid <= 1'b0;
            req_up = 1'b0;
        end
    endtask

    // Let every owed answer come back before changing the traffic shape
    task automatic wait_for_answers();
        while (owed_answers.size() != 0) @(posedge i_clk);
    endtask

    task automatic compare_answer(input t_result got);
        t_partition_answer want;
        if (owed_answers.size() == 0) begin
            if (mismatch_count < MAX_REPORTS) begin
                $display("unexpected result: partitions %0d with nothing owed", got);
            end
            mismatch_count++;
        end else begin
            want = owed_answers.pop_front();
            if (got !== want.partitions) begin
                if (mismatch_count < MAX_REPORTS) begin
                    $display("count %0d: partitions expected %0d, got %0d",
                             want.count, want.partitions, got);
                end
                mismatch_count++;
            end
        end
    endtask

    // Result side: check each transaction, then pick the next ready level
    always @(posedge i_clk) begin
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            compare_answer(res_ch.partitions);
        end
        if (rx_mode == RX_OPEN) begin
            ready_level = 1'b1;
            ready_run   = 0;
        end else if (ready_run > 0) begin
            ready_run--;
        end else if (rx_mode == RX_LONG_STALL) begin
            ready_level = ~ready_level;
            ready_run   = ready_level ? 0 : 60;
        end else if (ready_level) begin
            ready_level = 1'b0;
            ready_run   = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 120)
                                                      : $urandom_range(0, 6);
        end else begin
            ready_level = 1'b1;
            ready_run   = $urandom_range(0, 15);
        end
        res_ch.ready <= ready_level;
    end

    // Watchdog: the limit grows with the work sent
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > cycle_limit) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic test_zero_count();
        rx_mode = RX_OPEN;
        tx_mode = TX_STEADY;
        send_count(8'd0);
        stop_sending();
        wait_for_answers();
    endtask

    task automatic test_small_counts();
        for (int n = 1; n <= 5; n++) begin
            send_count(t_count'(n));
        end
        stop_sending();
        wait_for_answers();
    endtask

    // Largest row, all-ones / alternating bit patterns and the msb boundary
    task automatic test_field_extremes();
        t_count picks [6] = '{8'd255, 8'd254, 8'd128, 8'd127, 8'd170, 8'd85};
        rx_mode = RX_CHOPPY;
        foreach (picks[i]) begin
            send_count(picks[i]);
        end
        stop_sending();
        wait_for_answers();
    endtask

    // Quick results pile up behind a stalled receiver
    task automatic test_held_results();
        t_count picks [6] = '{8'd0, 8'd0, 8'd1, 8'd2, 8'd0, 8'd3};
        rx_mode = RX_LONG_STALL;
        foreach (picks[i]) begin
            send_count(picks[i]);
        end
        stop_sending();
        wait_for_answers();
    endtask

    task automatic test_bursty_traffic();
        t_count picks [5] = '{8'd6, 8'd7, 8'd12, 8'd20, 8'd33};
        rx_mode = RX_CHOPPY;
        tx_mode = TX_BURSTY;
        foreach (picks[i]) begin
            send_count(picks[i]);
        end
        stop_sending();
        wait_for_answers();
    endtask

    // Mostly short rows, a few up to the largest; traffic shape changes per phase
    task automatic test_random_counts();
        int pick;
        for (int phase = 0; phase < 5; phase++) begin
            rx_mode = (phase == 0) ? RX_OPEN : (phase == 3) ? RX_LONG_STALL : RX_CHOPPY;
            tx_mode = (phase == 0 || phase == 2) ? TX_STEADY : TX_BURSTY;
            for (int i = 0; i < 16; i++) begin
                pick = $urandom_range(0, 99);
                if (pick < 4) begin
                    send_count(t_count'($urandom_range(0, MAX_COUNT)));
                end else begin
                    send_count(t_count'($urandom_range(0, 48)));
                end
            end
            stop_sending();
            wait_for_answers();
        end
    endtask

    // Reset, then the tests in turn
    initial begin
        i_rst_n         = 1'b0;
        req_ch.valid    = 1'b0;
        req_ch.count_in = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_zero_count();
        test_small_counts();
        test_field_extremes();
        test_held_results();
        test_bursty_traffic();
        test_random_counts();
        repeat (SETTLE_TICKS) @(posedge i_clk);
        if (mismatch_count == 0 && owed_answers.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

### filelist.f
+incdir+sv
sv/ipc_pkg.sv
sv/ipc_if.sv
sv/ipc_ram.sv
sv/integer_partition_counter.sv
sv/ipc_checker.sv
dv/integer_partition_counter_test.sv
